// File: sv/shot_to_shot_abs_difference_defines.svh
// -----------------------------------------------------------------------------
// shot_to_shot_abs_difference assertion macros
// shared property templates for the shot-to-shot difference block
// -----------------------------------------------------------------------------
`ifndef SHOT_TO_SHOT_ABS_DIFFERENCE_DEFINES_SVH
`define SHOT_TO_SHOT_ABS_DIFFERENCE_DEFINES_SVH

// same-cycle implication
`define STSAD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STSAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/stsad_pkg.sv
// -----------------------------------------------------------------------------
// stsad_pkg
// widths, constants and types of the shot-to-shot difference block
// -----------------------------------------------------------------------------
package stsad_pkg;

  localparam int unsigned MAX_POINTS_DEF = 4096;

  localparam int unsigned SAMPLE_W       = 32;
  localparam int unsigned LIMIT_W        = 13;
  localparam int unsigned SUM_W          = 35;
  localparam int unsigned IN_TDATA_W     = 32;
  localparam int unsigned OUT_TDATA_W    = 40;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd1024;

  // floor(x / 1000) = floor(floor(x / 8) / 125), the latter by reciprocal
  localparam int unsigned MAG_W          = SAMPLE_W + 1;
  localparam int unsigned PRE_SHIFT      = 3;
  localparam int unsigned SCALED_W       = MAG_W - PRE_SHIFT;
  localparam int unsigned RECIP_W        = 31;
  localparam int unsigned RECIP_SHIFT    = 37;
  localparam int unsigned PROD_W         = SCALED_W + RECIP_W;
  localparam int unsigned QUOT_W         = PROD_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_125 = 31'd1099511628;

  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctrl_t;

endpackage

// File: sv/shot_to_shot_abs_difference.sv
// -----------------------------------------------------------------------------
// shot_to_shot_abs_difference: one transaction per cycle unless a held result blocks
// the next one; a result follows the last sample via read, abs, reciprocal multiply, sum
// bank memory: one write port (used on in-range acceptance) and one registered read port (used at acceptance)
// async reset clears control, per-bank fill counts and the accumulator; no sweep
// -----------------------------------------------------------------------------
`include "shot_to_shot_abs_difference_defines.svh"

module shot_to_shot_abs_difference
  import stsad_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [LIMIT_W-1:0]     cfg_wdata_i,     // point_limit
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // [31:0] sample
  input  logic                   s_axis_tlast_i,  // last_of_shot
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o   // [34:0] difference_sum
);

  localparam int unsigned IW    = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned DEPTH = 2 ** (AW + 1);

  logic [LIMIT_W-1:0]  limit_q;
  logic                bank_q;
  logic [IW-1:0]       idx_q;
  logic [IW-1:0]       fill_q [2];
  logic [SUM_W-1:0]    run_q;

  logic [SAMPLE_W-1:0] mem_q [DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;

  stage_ctrl_t         s1_q, s2_q, s3_q;
  logic                inr1_q, pv1_q;
  logic [SAMPLE_W-1:0] sample1_q;
  logic [MAG_W-1:0]    mag2_q;
  logic [QUOT_W-1:0]   quot3_q;

  logic                out_valid_q;
  logic [SUM_W-1:0]    out_data_q;

  logic                en, accept, in_range, prev_valid;
  logic [IW-1:0]       lim;
  logic [31:0]         limit_ext;
  logic [AW:0]         waddr, raddr;
  logic [MAG_W-1:0]    diff, mag_d;
  logic [SAMPLE_W-1:0] prev_sample;
  logic [PROD_W-1:0]   prod;
  logic [SUM_W:0]      sum_ext;
  logic [SUM_W-1:0]    sum_sat;

  // effective limit
  always_comb begin
    limit_ext = 32'(limit_q);
    if (limit_q == '0) begin
      lim = IW'(1);
    end else if (limit_ext > 32'(MAX_POINTS)) begin
      lim = IW'(MAX_POINTS);
    end else begin
      lim = IW'(limit_q);
    end
  end

  assign en              = !(s3_q.valid && s3_q.last && out_valid_q && !m_axis_tready_i);
  assign s_axis_tready_o = en;
  assign accept          = s_axis_tvalid_i && en;
  assign in_range        = idx_q < lim;
  assign prev_valid      = idx_q < fill_q[~bank_q];
  assign waddr           = {bank_q, idx_q[AW-1:0]};
  assign raddr           = {~bank_q, idx_q[AW-1:0]};

  // bank memory
  always_ff @(posedge clk_i) begin
    if (accept && in_range) begin
      mem_q[waddr] <= s_axis_tdata_i[SAMPLE_W-1:0];
    end
    if (accept) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // abs difference
  always_comb begin
    prev_sample = pv1_q ? rdata_q : '0;
    diff  = {sample1_q[SAMPLE_W-1], sample1_q} - {prev_sample[SAMPLE_W-1], prev_sample};
    mag_d = diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;
  end

  assign prod    = PROD_W'(mag2_q[MAG_W-1:PRE_SHIFT]) * PROD_W'(RECIP_125);
  assign sum_ext = {1'b0, run_q} + (SUM_W + 1)'(quot3_q);
  assign sum_sat = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample1_q <= s_axis_tdata_i[SAMPLE_W-1:0];
      inr1_q    <= in_range;
      pv1_q     <= prev_valid;
    end
    if (en) begin
      mag2_q  <= inr1_q ? mag_d : '0;
      quot3_q <= prod[PROD_W-1:RECIP_SHIFT];
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LIMIT_RESET;
      bank_q      <= 1'b0;
      idx_q       <= '0;
      fill_q[0]   <= '0;
      fill_q[1]   <= '0;
      run_q       <= '0;
      s1_q        <= '0;
      s2_q        <= '0;
      s3_q        <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (accept) begin
        if (in_range && (idx_q >= fill_q[bank_q])) begin
          fill_q[bank_q] <= idx_q + IW'(1);
        end
        if (s_axis_tlast_i) begin
          idx_q  <= '0;
          bank_q <= ~bank_q;
        end else if (in_range) begin
          idx_q <= idx_q + IW'(1);
        end
      end
      if (en) begin
        s1_q.valid <= accept;
        s1_q.last  <= s_axis_tlast_i;
        s2_q       <= s1_q;
        s3_q       <= s2_q;
      end
      if (en && s3_q.valid) begin
        if (s3_q.last) begin
          run_q      <= '0;
          out_data_q <= sum_sat;
        end else begin
          run_q <= sum_sat;
        end
      end
      if (en && s3_q.valid && s3_q.last) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(out_data_q);

  `STSAD_ASSERT_NOW(a_idx_le_lim, 1'b1, idx_q <= IW'(MAX_POINTS), "point index past max")
  `STSAD_ASSERT_NOW(a_stall_cause, !s_axis_tready_o, out_valid_q && !m_axis_tready_i,
                    "input stalled without blocked result")
  `STSAD_ASSERT_NEXT(a_result_out, en && s3_q.valid && s3_q.last, m_axis_tvalid_o,
                     "last sample produced no result")
  `STSAD_ASSERT_NEXT(a_bank_swap, accept && s_axis_tlast_i,
                     bank_q != $past(bank_q) && idx_q == '0,
                     "bank did not swap at end of shot")

endmodule
